// ===== rtl/bba_pkg.sv =====
// bba_pkg: shared types, constants and helper functions of the bitmap block allocator
// no dependencies; imported by bba_ctrl and bitmap_block_allocator
`default_nettype none

package bba_pkg;

   // sizing of the block map
   localparam int NUM_BLOCKS  = 64;
   localparam int MAP_BYTES   = 8;
   localparam int MAP_BITS    = MAP_BYTES * 8;
   localparam int LIVE_BITS   = (NUM_BLOCKS < MAP_BITS) ? NUM_BLOCKS : MAP_BITS;
   localparam int RESET_COUNT = LIVE_BITS - 1;
   localparam int MAP_AW      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_W       = $clog2(MAP_BITS + 1);
   localparam int COUNT_MAX   = 127;

   // field widths
   localparam int CMD_W   = 2;
   localparam int BLOCK_W = 6;
   localparam int COUNT_W = 7;

   // command codes; the fourth code is a no-op
   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_LOOK,
      ST_REPLY
   } bba_state_type;

   // one result word
   typedef struct packed {
      logic [COUNT_W-1:0] free_count;
      logic               alloc_failed;
      logic [BLOCK_W-1:0] granted_block;
   } res_type;

   // bits of map byte row that belong to blocks 1 to NUM_BLOCKS-1
   function automatic logic [7:0] init_byte(input int unsigned row);
      logic [7:0] pat;
      int unsigned blk;
      pat = '0;
      for (int b = 0; b < 8; b++) begin
         blk = row * 8 + b;
         pat[b] = (blk >= 1) && (blk < NUM_BLOCKS);
      end
      return pat;
   endfunction

   // number of set bits in a byte
   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int b = 0; b < 8; b++) begin
         n = n + {3'd0, v[b]};
      end
      return n;
   endfunction

   // position of the lowest set bit of a byte
   function automatic logic [2:0] lowest_set(input logic [7:0] v);
      logic [2:0] pos;
      pos = '0;
      for (int b = 7; b >= 0; b--) begin
         if (v[b]) begin
            pos = 3'(b);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// bba_ram: generic single-write, single-read synchronous memory, registered read data
// no dependencies
`default_nettype none

module bba_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// bba_ctrl: sequencer that scans and updates the free map byte by byte and keeps the count
// depends on bba_pkg; drives the map memory bba_ram
`default_nettype none

module bba_ctrl
   import bba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request word
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [BLOCK_W-1:0] req_index,
   // map memory
   output logic                    wr_en,
   output logic [MAP_AW-1:0]       wr_addr,
   output logic [7:0]              wr_data,
   output logic                    rd_en,
   output logic [MAP_AW-1:0]       rd_addr,
   input  wire logic [7:0]         rd_data,
   // finished result
   output logic                    res_valid,
   input  wire logic               res_ready,
   output res_type                 res
);

   localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_BYTES - 1);

   bba_state_type        state_ff, state_in;
   logic [MAP_AW-1:0]    addr_ff, addr_in;
   cmd_type              cmd_ff, cmd_in;
   logic [BLOCK_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   res_type              res_ff, res_in;

   logic                 req_fire;
   logic                 look_done;
   logic                 last_byte;
   logic                 free_in_range;
   logic [MAP_AW-1:0]    free_addr;
   logic [7:0]           free_mask;
   logic [7:0]           init_pat;
   logic [2:0]           low_pos;
   logic [COUNT_W-1:0]   count_sat;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign last_byte     = (addr_ff == LAST_ADDR);
   assign free_in_range = (9'(idx_ff) < 9'(LIVE_BITS));
   assign free_addr     = MAP_AW'(idx_ff[BLOCK_W-1:3]);
   assign free_mask     = 8'(1) << idx_ff[2:0];
   assign init_pat      = init_byte(int'(addr_ff));
   assign low_pos       = lowest_set(rd_data);
   assign count_sat     = (int'(cnt_ff) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt_ff);
   assign res_valid     = (state_ff == ST_REPLY);
   assign res           = res_ff;

   // datapath and memory control
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = addr_ff + MAP_AW'(1);
      addr_in   = addr_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      look_done = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            // reset pass writes the initial free pattern
            wr_en   = 1'b1;
            wr_data = init_pat;
            addr_in = last_byte ? '0 : addr_ff + MAP_AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = cmd_type'(req_cmd);
               idx_in  = req_index;
               rd_en   = 1'b1;
               rd_addr = (cmd_type'(req_cmd) == CMD_FREE) ?
                         MAP_AW'(req_index[BLOCK_W-1:3]) : '0;
               addr_in = rd_addr;
            end
         end
         ST_LOOK: begin
            res_in.granted_block = '0;
            res_in.alloc_failed  = 1'b0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (rd_data != 8'd0) begin
                     wr_en   = 1'b1;
                     wr_data = rd_data & ~(8'(1) << low_pos);
                     cnt_in  = cnt_ff - CNT_W'(1);
                     res_in.granted_block = BLOCK_W'({addr_ff, low_pos});
                     look_done = 1'b1;
                  end else if (last_byte) begin
                     res_in.alloc_failed = 1'b1;
                     look_done = 1'b1;
                  end else begin
                     // read ahead the next byte
                     rd_en   = 1'b1;
                     addr_in = addr_ff + MAP_AW'(1);
                  end
               end
               CMD_INIT: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | init_pat;
                  cnt_in  = cnt_ff + CNT_W'(pop8(init_pat & ~rd_data));
                  if (last_byte) begin
                     look_done = 1'b1;
                  end else begin
                     rd_en   = 1'b1;
                     addr_in = addr_ff + MAP_AW'(1);
                  end
               end
               CMD_FREE: begin
                  if (free_in_range) begin
                     wr_en   = 1'b1;
                     wr_addr = free_addr;
                     wr_data = rd_data | free_mask;
                     if ((rd_data & free_mask) == 8'd0) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  look_done = 1'b1;
               end
               default: begin
                  look_done = 1'b1;
               end
            endcase
         end
         ST_REPLY: begin
            addr_in = '0;
         end
         default: begin
         end
      endcase
      // result word count follows the updated counter
      res_in.free_count = (int'(cnt_in) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt_in);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL:  if (last_byte) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_LOOK;
         ST_LOOK:  if (look_done) state_in = ST_REPLY;
         ST_REPLY: if (res_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         addr_ff  <= '0;
         cnt_ff   <= CNT_W'(RESET_COUNT);
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

`ifndef ASSERT_OFF
   // the exact count never exceeds the map size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= MAP_BITS)
      else $error("free count above map size");

   // a read-ahead never targets the byte being written
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write to the same map byte");

   // a failed alloc only happens on an empty map
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && res_ff.alloc_failed) |-> (cnt_ff == '0))
      else $error("alloc failed with free blocks left");

   // a reply carries the current count
   a_reply_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY) |-> (res_ff.free_count == count_sat))
      else $error("reply count out of step");
`endif

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator.sv =====
// bitmap_block_allocator: top level, lowest-free-block allocator over a byte-wide free map
// depends on bba_pkg, bba_ram and bba_ctrl
//
//   channel  ports      tdata (low bit up)                      tuser
//   request  req_*      block_index[5:0], zeros[7:6]            cmd[1:0]
//   result   rsp_*      granted_block[5:0], free_count[12:6],   alloc_failed
//                       zeros[15:13]
//
// an item enters through the idle state, is scanned in the map (one map byte per
// cycle through the single read port; alloc stops at the first nonzero byte, init
// always visits every byte, free takes one), then passes the reply state to the
// output register.
// after reset a pass over all MAP_BYTES map bytes writes the initial map; req_tready is low then.
// a new word is taken while the previous result still waits in the output register;
// a result stalled behind it holds the sequencer in its reply state.
`default_nettype none

module bitmap_block_allocator
   import bba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // block_index[5:0], pad[7:6]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // granted_block[5:0], free_count[12:6], pad[15:13]
   output logic             rsp_tuser    // alloc_failed
);

   logic              wr_en;
   logic [MAP_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [MAP_AW-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              res_valid;
   logic              res_ready;
   res_type           res;

   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff;

   // sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_index (req_tdata[BLOCK_W-1:0]),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // free map storage
   bba_ram #(
      .DEPTH (MAP_BYTES),
      .WIDTH (8),
      .AW    (MAP_AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.free_count, rsp_ff.granted_block};
   assign rsp_tuser  = rsp_ff.alloc_failed;

endmodule

`default_nettype wire
